/* hw/rtl/ict_pkg.sv */
// Shared types, constants and tables of the complementary tilt filter.
`timescale 1ns / 1ps
`default_nettype none
package ict_pkg;

    localparam int ACC_FRAC     = 16;  // fractional bits of the CORDIC angle accumulator
    localparam int INPUT_SCALE  = 8;
    localparam int Z_W          = 26;  // CORDIC angle accumulator width
    localparam int XY_W         = 28;  // CORDIC vector width
    localparam int SQ_N_W       = 48;  // radicand width
    localparam int SQ_ROOT_W    = 24;
    localparam int SQ_REM_W     = 27;
    localparam int SQ_STEPS     = 24;
    localparam int DEN_W        = 36;  // sensitivity times one million
    localparam int MAG_W        = 31;  // |rate| times microseconds
    localparam int STEP_W       = 6;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SENS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 8'd1;

    localparam logic [15:0] SENS_RESET   = 16'd131;
    localparam logic [15:0] WEIGHT_RESET = 16'd32113;
    localparam logic [15:0] WEIGHT_ONE   = 16'd32768;
    localparam logic [19:0] US_PER_S     = 20'd1000000;
    localparam logic signed [Z_W-1:0] HALF_TURN = 26'sd11796480;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic        [15:0] elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_RUN,
        S_PLOAD,
        S_PRUN,
        S_FIN,
        S_MUL,
        S_MIX
    } t_state;

    typedef struct packed {
        logic              take;
        logic              prep;
        logic              load;
        logic              run;
        logic              pload;
        logic              prun;
        logic              fin;
        logic              mul;
        logic              mix;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ict_ctrl.sv */
// Sequencer of the tilt filter: steps the datapath through one sample.
`timescale 1ns / 1ps
`default_nettype none
module ict_ctrl #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_busy,
    output logic                  o_in_ready,
    output ict_pkg::t_dp_cmd      o_cmd
);
    import ict_pkg::*;

    localparam int NUM_W = 32 + ANGLE_FRAC_BITS;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP;
            S_PREP:  n_state = S_LOAD;
            S_LOAD: begin
                n_state = S_RUN;
                n_cnt   = '0;
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(NUM_W - 1)) n_state = S_PLOAD;
            end
            S_PLOAD: begin
                n_state = S_PRUN;
                n_cnt   = '0;
            end
            S_PRUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(CORDIC_ITERATIONS - 1)) n_state = S_FIN;
            end
            S_FIN:   n_state = S_MUL;
            S_MUL:   n_state = S_MIX;
            S_MIX:   if (!i_out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.step  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_PREP:  o_cmd.prep  = 1'b1;
            S_LOAD:  o_cmd.load  = 1'b1;
            S_RUN:   o_cmd.run   = 1'b1;
            S_PLOAD: o_cmd.pload = 1'b1;
            S_PRUN:  o_cmd.prun  = 1'b1;
            S_FIN:   o_cmd.fin   = 1'b1;
            S_MUL:   o_cmd.mul   = 1'b1;
            S_MIX:   o_cmd.mix   = !i_out_busy;
            default: o_cmd       = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/ict_dp.sv */
// Datapath of the tilt filter: square root, CORDIC, gyro dividers and blend.
`timescale 1ns / 1ps
`default_nettype none
module ict_dp #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ict_pkg::t_dp_cmd            i_cmd,
    input  wire ict_pkg::t_in_word           i_in_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [ict_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                 i_cfg_data,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output ict_pkg::t_out_word               o_out_data
);
    import ict_pkg::*;

    localparam int AFB   = ANGLE_FRAC_BITS;
    localparam int NUM_W = 32 + AFB;       // dividend width
    localparam int R_W   = DEN_W + 1;      // divider remainder width
    localparam int Q_W   = 13 + AFB;       // signed gyro increment width
    localparam int OI_W  = 14 + AFB;       // old angle plus increment
    localparam int A_W   = 10 + AFB;       // accelerometer angle width
    localparam int P_W   = OI_W + 17;
    localparam int S_W   = P_W + 1;
    localparam int ZSH   = ACC_FRAC - AFB;

    // configuration and state
    logic [15:0]        r_sens, r_weight;
    logic signed [15:0] r_roll, r_pitch;
    t_in_word           r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens   <= SENS_RESET;
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_GYRO_SENS)    r_sens   <= i_cfg_data;
            if (i_cfg_idx == CFG_BLEND_WEIGHT) r_weight <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_in <= i_in_data;
    end

    // first products
    logic [31:0]       r_ayy, r_azz;
    logic [MAG_W-1:0]  r_magx, r_magy;
    logic [DEN_W-1:0]  r_den;
    logic [15:0]       sens_eff, abs_gx, abs_gy;

    assign sens_eff = (r_sens == 16'd0) ? 16'd1 : r_sens;
    assign abs_gx   = r_in.gyro_x[15] ? 16'(-r_in.gyro_x) : 16'(r_in.gyro_x);
    assign abs_gy   = r_in.gyro_y[15] ? 16'(-r_in.gyro_y) : 16'(r_in.gyro_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_ayy  <= 32'(32'(r_in.accel_y) * 32'(r_in.accel_y));
            r_azz  <= 32'(32'(r_in.accel_z) * 32'(r_in.accel_z));
            r_magx <= MAG_W'(abs_gx) * MAG_W'(r_in.elapsed_us);
            r_magy <= MAG_W'(abs_gy) * MAG_W'(r_in.elapsed_us);
            r_den  <= DEN_W'(sens_eff) * DEN_W'(US_PER_S);
        end
    end

    // square root, two radicand bits a step
    logic [SQ_N_W-1:0]    r_sq_n;
    logic [SQ_REM_W-1:0]  r_sq_rem, sq_rem_s, sq_trial;
    logic [SQ_ROOT_W-1:0] r_sq_root;

    assign sq_rem_s = {r_sq_rem[SQ_REM_W-3:0], r_sq_n[SQ_N_W-1 -: 2]};
    assign sq_trial = {1'b0, r_sq_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq_n    <= {r_ayy + r_azz, 16'd0};
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.run && i_cmd.step < STEP_W'(SQ_STEPS)) begin
            r_sq_n <= {r_sq_n[SQ_N_W-3:0], 2'b00};
            if (sq_rem_s >= sq_trial) begin
                r_sq_rem  <= sq_rem_s - sq_trial;
                r_sq_root <= {r_sq_root[SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_rem_s;
                r_sq_root <= {r_sq_root[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

    // two restoring dividers, quotient shifts into the dividend register
    logic [NUM_W-1:0] r_num_x, r_num_y;
    logic [R_W-1:0]   r_rem_x, r_rem_y, rem_sx, rem_sy, den_ext;

    assign den_ext = {1'b0, r_den};
    assign rem_sx  = {r_rem_x[R_W-2:0], r_num_x[NUM_W-1]};
    assign rem_sy  = {r_rem_y[R_W-2:0], r_num_y[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num_x <= (NUM_W'(r_magx) << AFB) + NUM_W'(r_den >> 1);
            r_num_y <= (NUM_W'(r_magy) << AFB) + NUM_W'(r_den >> 1);
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (i_cmd.run) begin
            if (rem_sx >= den_ext) begin
                r_rem_x <= rem_sx - den_ext;
                r_num_x <= {r_num_x[NUM_W-2:0], 1'b1};
            end else begin
                r_rem_x <= rem_sx;
                r_num_x <= {r_num_x[NUM_W-2:0], 1'b0};
            end
            if (rem_sy >= den_ext) begin
                r_rem_y <= rem_sy - den_ext;
                r_num_y <= {r_num_y[NUM_W-2:0], 1'b1};
            end else begin
                r_rem_y <= rem_sy;
                r_num_y <= {r_num_y[NUM_W-2:0], 1'b0};
            end
        end
    end

    // vectoring CORDIC, shared by roll and pitch
    logic signed [XY_W-1:0] r_cx, r_cy, n_cx, n_cy, init_x, init_y, dx, dy;
    logic signed [Z_W-1:0]  r_cz, n_cz, z_rnd;
    logic                   r_czero;
    logic signed [A_W-1:0]  angle, r_acc_roll, r_acc_pitch;
    logic                   c_step;
    logic [4:0]             c_idx;

    assign c_idx  = i_cmd.step[4:0];
    assign c_step = (i_cmd.run && i_cmd.step < STEP_W'(CORDIC_ITERATIONS)) || i_cmd.prun;
    assign init_x = i_cmd.load ? XY_W'(r_in.accel_z) <<< INPUT_SCALE
                               : $signed(XY_W'(r_sq_root));
    assign init_y = i_cmd.load ? XY_W'(r_in.accel_y) <<< INPUT_SCALE
                               : -(XY_W'(r_in.accel_x) <<< INPUT_SCALE);
    assign dx     = r_cy >>> c_idx;
    assign dy     = r_cx >>> c_idx;
    assign z_rnd  = r_cz + (Z_W'(1) <<< (ZSH - 1));
    assign angle  = r_czero ? '0 : A_W'(z_rnd >>> ZSH);

    always_comb begin
        if (r_cy < 0) begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - atan_entry(c_idx);
        end else begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + atan_entry(c_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.pload) begin
            r_czero <= (init_x == '0) && (init_y == '0);
            if (init_x < 0) begin
                r_cx <= -init_x;
                r_cy <= -init_y;
                r_cz <= (init_y >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_cx <= init_x;
                r_cy <= init_y;
                r_cz <= '0;
            end
        end else if (c_step) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
        if (i_cmd.pload) r_acc_roll  <= angle;
        if (i_cmd.fin)   r_acc_pitch <= angle;
    end

    // blend
    logic signed [Q_W-1:0]  inc_x, inc_y;
    logic signed [OI_W-1:0] oi_roll, oi_pitch;
    logic signed [16:0]     w_g, w_a;
    logic [15:0]            w_eff;
    logic signed [P_W-1:0]  r_pg_roll, r_pa_roll, r_pg_pitch, r_pa_pitch;
    logic signed [S_W-1:0]  s_roll, s_pitch;
    logic signed [15:0]     roll_new, pitch_new;

    assign inc_x = r_in.gyro_x[15] ? -$signed({1'b0, r_num_x[Q_W-2:0]})
                                   :  $signed({1'b0, r_num_x[Q_W-2:0]});
    assign inc_y = r_in.gyro_y[15] ? -$signed({1'b0, r_num_y[Q_W-2:0]})
                                   :  $signed({1'b0, r_num_y[Q_W-2:0]});
    assign oi_roll  = OI_W'(r_roll)  + OI_W'(inc_x);
    assign oi_pitch = OI_W'(r_pitch) + OI_W'(inc_y);
    assign w_eff    = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign w_g      = $signed({1'b0, w_eff});
    assign w_a      = $signed({1'b0, 16'(WEIGHT_ONE - w_eff)});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_pg_roll  <= P_W'(oi_roll) * P_W'(w_g);
            r_pa_roll  <= P_W'(r_acc_roll) * P_W'(w_a);
            r_pg_pitch <= P_W'(oi_pitch) * P_W'(w_g);
            r_pa_pitch <= P_W'(r_acc_pitch) * P_W'(w_a);
        end
    end

    function automatic logic signed [15:0] round_sat(input logic signed [S_W-1:0] s);
        logic signed [S_W-1:0] r;
        r = (s + S_W'(16384)) >>> 15;
        if (r > S_W'(32767))       return 16'sd32767;
        else if (r < -S_W'(32768)) return -16'sd32768;
        else                       return r[15:0];
    endfunction

    assign s_roll    = S_W'(r_pg_roll)  + S_W'(r_pa_roll);
    assign s_pitch   = S_W'(r_pg_pitch) + S_W'(r_pa_pitch);
    assign roll_new  = round_sat(s_roll);
    assign pitch_new = round_sat(s_pitch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll  <= '0;
            r_pitch <= '0;
        end else if (i_cmd.mix) begin
            r_roll  <= roll_new;
            r_pitch <= pitch_new;
        end
    end

    // output word register
    logic      r_out_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.mix) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_out.roll_out  <= roll_new;
            r_out.pitch_out <= pitch_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* hw/rtl/imu_complementary_tilt_filter.sv */
// Complementary roll and pitch filter for raw six-axis IMU samples.
//
// Input channel: one word per sample (three accelerometer axes, X and Y gyro
// rates, microseconds since the last sample), valid/ready. Output channel:
// one word per sample with the new roll and pitch in signed degrees with
// ANGLE_FRAC_BITS fractional bits, valid/ready.
// Configuration: write gyro_sensitivity (index 0) and blend_weight (index 1)
// through i_cfg_we/i_cfg_idx/i_cfg_data while no sample is in flight.
// One sample at a time: a new sample is taken in the same cycle as the word
// of the last one becomes valid. The run is set by the bit-serial gyro
// dividers (32 + ANGLE_FRAC_BITS steps, alongside the square root and the
// roll CORDIC) followed by the pitch CORDIC pass.
// The result sits in an output register; the next sample is accepted and
// processed while it waits, and the sequencer holds before its final
// write until that word is taken.
// Reset clears the roll and pitch estimates, loads the default
// configuration and drops any word in flight.
`timescale 1ns / 1ps
`default_nettype none
module imu_complementary_tilt_filter #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire ict_pkg::t_in_word             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ict_pkg::t_out_word                 o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [ict_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_data
);
    import ict_pkg::*;

    t_dp_cmd cmd;
    logic    out_busy;

    assign out_busy = o_out_valid && !i_out_ready;

    ict_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ict_dp #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while one is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mix |-> !out_busy)
        else $error("result written over a word not yet taken");

    a_mix_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mix |=> o_out_valid)
        else $error("finished sample produced no output word");

endmodule
`default_nettype wire

/* tb/sv/imu_complementary_tilt_filter_tb.sv */
// Self-checking testbench for the complementary roll and pitch tilt filter.
`timescale 1ns / 1ps

class tilt_scoreboard;
    localparam longint HALF_TURN_Q16 = 180 * 65536;
    localparam int     ITERS         = 16;
    localparam int     FRAC          = 7;

    longint            atan_q16[24];
    ict_pkg::t_out_word pending_words[$];
    int unsigned       sens_reg;
    int unsigned       weight_reg;
    logic signed [15:0] roll_est;
    logic signed [15:0] pitch_est;
    int                n_errors;

    function new();
        atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
        sens_reg   = 131;
        weight_reg = 32113;
        roll_est   = 0;
        pitch_est  = 0;
        n_errors   = 0;
    endfunction

    function void set_reg(int unsigned idx, int unsigned val);
        if (idx == ict_pkg::CFG_GYRO_SENS) sens_reg = val & 16'hFFFF;
        else if (idx == ict_pkg::CFG_BLEND_WEIGHT) weight_reg = val & 16'hFFFF;
    endfunction

    // atan2(y, x) in degrees with FRAC fractional bits
    function longint tilt_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx;
                y += dy;
                z -= atan_q16[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q16[i];
            end
        end
        return (z + (64'sd1 << (16 - FRAC - 1))) >>> (16 - FRAC);
    endfunction

    function longint isqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function longint gyro_inc(longint rate, longint unsigned us);
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        den = longint'(sens_reg != 0 ? sens_reg : 1) * 64'd1000000;
        mag = ((rate < 0 ? -rate : rate) * us) << FRAC;
        q = (mag + den / 2) / den;
        return rate < 0 ? -longint'(q) : longint'(q);
    endfunction

    function logic signed [15:0] blend(longint old, longint inc, longint acc);
        longint w;
        longint s;
        longint r;
        w = weight_reg > 32768 ? 32768 : weight_reg;
        s = (old + inc) * w + acc * (32768 - w);
        r = (s + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function void note_sample(ict_pkg::t_in_word w);
        longint ax;
        longint ay;
        longint az;
        longint unsigned sq;
        ict_pkg::t_out_word res;
        ax = w.accel_x;
        ay = w.accel_y;
        az = w.accel_z;
        sq = longint'(ay * ay + az * az) << 16;
        roll_est  = blend(roll_est, gyro_inc(w.gyro_x, w.elapsed_us),
                          tilt_angle(ay * 256, az * 256));
        pitch_est = blend(pitch_est, gyro_inc(w.gyro_y, w.elapsed_us),
                          tilt_angle(-ax * 256, isqrt(sq)));
        res.roll_out  = roll_est;
        res.pitch_out = pitch_est;
        pending_words.push_back(res);
    endfunction

    function void check_word(ict_pkg::t_out_word got);
        ict_pkg::t_out_word exp_w;
        if (pending_words.size() == 0) begin
            $error("output word with nothing pending: %h", got);
            n_errors++;
            return;
        end
        exp_w = pending_words.pop_front();
        if (got.roll_out !== exp_w.roll_out) begin
            $error("roll_out expected %0d actual %0d", exp_w.roll_out, got.roll_out);
            n_errors++;
        end
        if (got.pitch_out !== exp_w.pitch_out) begin
            $error("pitch_out expected %0d actual %0d", exp_w.pitch_out, got.pitch_out);
            n_errors++;
        end
    endfunction
endclass

module imu_complementary_tilt_filter_tb;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    ict_pkg::t_in_word             i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    ict_pkg::t_out_word            o_out_data;
    logic                          i_cfg_we;
    logic [ict_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]                   i_cfg_data;

    tilt_scoreboard sb;
    bit             no_idle;
    int             hold_left;
    int             quiet_cycles;

    imu_complementary_tilt_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: check words, idle at random, honor long hold-offs
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_out_data);
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("imu_complementary_tilt_filter verification failed");
            $finish;
        end
    end

    task automatic send_sample(ict_pkg::t_in_word w);
        int gap;
        gap = (no_idle || $urandom_range(99) >= 12) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(w);
    endtask

    task automatic wait_drained();
        while (sb.pending_words.size() != 0) @(posedge i_clk);
    endtask

    // hold valid low, drain, let the sequencer settle, then write
    task automatic write_regs(int unsigned sens, int unsigned weight);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ict_pkg::CFG_GYRO_SENS;
        i_cfg_data <= 16'(sens);
        @(posedge i_clk);
        sb.set_reg(ict_pkg::CFG_GYRO_SENS, sens);
        i_cfg_idx  <= ict_pkg::CFG_BLEND_WEIGHT;
        i_cfg_data <= 16'(weight);
        @(posedge i_clk);
        sb.set_reg(ict_pkg::CFG_BLEND_WEIGHT, weight);
        // unknown index: must be dropped
        i_cfg_idx  <= 8'(2 + $urandom_range(253));
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic ict_pkg::t_in_word make_sample(int ax, int ay, int az, int gx, int gy,
                                                      int us);
        ict_pkg::t_in_word w;
        w.accel_x    = 16'(ax);
        w.accel_y    = 16'(ay);
        w.accel_z    = 16'(az);
        w.gyro_x     = 16'(gx);
        w.gyro_y     = 16'(gy);
        w.elapsed_us = 16'(us);
        return w;
    endfunction

    // mostly gravity-like samples near level, the rest raw noise
    function automatic ict_pkg::t_in_word rand_sample();
        ict_pkg::t_in_word w;
        w = '0;
        w.elapsed_us = 16'($urandom);
        if ($urandom_range(99) < 60) begin
            w.accel_x    = 16'($signed($urandom_range(32000)) - 16000);
            w.accel_y    = 16'($signed($urandom_range(32000)) - 16000);
            w.accel_z    = 16'($signed($urandom_range(40000)) - 20000);
            w.gyro_x     = 16'($signed($urandom_range(2000)) - 1000);
            w.gyro_y     = 16'($signed($urandom_range(2000)) - 1000);
            w.elapsed_us = 16'($urandom_range(50, 20000));
        end else begin
            w.accel_x = 16'($urandom);
            w.accel_y = 16'($urandom);
            w.accel_z = 16'($urandom);
            w.gyro_x  = 16'($urandom);
            w.gyro_y  = 16'($urandom);
        end
        return w;
    endfunction

    initial begin
        int unsigned sens_set[5];
        int unsigned weight_set[5];
        sb = new();
        no_idle      = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples, first at reset configuration, then after register writes
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 16384, 0, 0, 10000));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 65535));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, 65535));
        send_sample(make_sample(0, 100, -16384, 500, -500, 100));
        send_sample(make_sample(0, -100, -16384, -500, 500, 100));
        send_sample(make_sample(0, 0, -16384, 0, 0, 0));
        send_sample(make_sample(16384, 0, 0, 1, -1, 1));
        send_sample(make_sample(-16384, 16384, 0, 0, 0, 0));
        send_sample(make_sample(1, 0, 0, 32767, 32767, 65535));
        send_sample(make_sample(-1, -1, 0, -32768, -32768, 65535));
        write_regs(1, 32768);
        repeat (4) send_sample(make_sample(0, 0, 1, 32767, -32768, 65535));
        write_regs(0, 65535);
        send_sample(make_sample(100, -200, 300, 32767, -32768, 65535));
        send_sample(make_sample(-100, 200, -300, 131, -131, 1));
        write_regs(65535, 0);
        send_sample(make_sample(32767, -32768, 0, 32767, 32767, 65535));
        send_sample(make_sample(0, 32767, -32768, -32768, -32768, 65535));

        sens_set   = '{131, 1, 65535, 250, 0};
        weight_set = '{32113, 32768, 0, 16384, 40000};
        for (int ph = 0; ph < 5; ph++) begin
            write_regs(sens_set[ph], weight_set[ph]);
            for (int k = 0; k < 300; k++) begin
                if (ph == 1 && k == 20) hold_left = 400;
                no_idle = (ph == 2 && k >= 50 && k < 200);
                if (ph == 3 && k == 150) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                    @(posedge i_clk);
                end
                send_sample(rand_sample());
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending_words.size() == 0)
            $display("imu_complementary_tilt_filter verification clean");
        else
            $display("imu_complementary_tilt_filter verification failed");
        $finish;
    end
endmodule

/* imu_complementary_tilt_filter.f */
hw/rtl/ict_pkg.sv
hw/rtl/ict_ctrl.sv
hw/rtl/ict_dp.sv
hw/rtl/imu_complementary_tilt_filter.sv
tb/sv/imu_complementary_tilt_filter_tb.sv
